// ----- hw/rtl/pda_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pda_pkg;

  // Event codes carried in the mode field
  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_ECHO   = 2'd1;
  localparam logic [1:0] MODE_BUTTON = 2'd2;

  // Distance bands, far to near
  localparam logic [2:0] BAND_FAR  = 3'd0;
  localparam logic [2:0] BAND_B1   = 3'd1;
  localparam logic [2:0] BAND_B2   = 3'd2;
  localparam logic [2:0] BAND_B3   = 3'd3;
  localparam logic [2:0] BAND_B4   = 3'd4;
  localparam logic [2:0] BAND_B5   = 3'd5;
  localparam logic [2:0] BAND_NEAR = 3'd6;

  // Digit positions in the display scan
  localparam logic [1:0] DIGIT_UNITS    = 2'd0;
  localparam logic [1:0] DIGIT_TENS     = 2'd1;
  localparam logic [1:0] DIGIT_HUNDREDS = 2'd2;

  // Scale register default, about 0.272 cm per count in Q16
  localparam logic [15:0] SCALE_RESET = 16'd17826;

  // Band limits on the Q16.16 distance
  localparam logic [31:0] LIMIT_200 = 32'd200 << 16;
  localparam logic [31:0] LIMIT_180 = 32'd180 << 16;
  localparam logic [31:0] LIMIT_120 = 32'd120 << 16;
  localparam logic [31:0] LIMIT_80  = 32'd80 << 16;
  localparam logic [31:0] LIMIT_50  = 32'd50 << 16;
  localparam logic [31:0] LIMIT_20  = 32'd20 << 16;

  // Reciprocals for the decimal split of a 16-bit value
  localparam logic [16:0] RECIP_10   = 17'd52429;  // >> 19
  localparam logic [16:0] RECIP_100  = 17'd83887;  // >> 23
  localparam logic [16:0] RECIP_1000 = 17'd67109;  // >> 26

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] echo_count;
  } pda_in_t;

  typedef struct packed {
    logic [3:0]  relays;
    logic        buzzer_on;
    logic        indicator_led;
    logic [2:0]  digit_select;
    logic [7:0]  segments;
    logic [15:0] distance_cm;
  } pda_out_t;

  // Word after the multiply stage
  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] prod;
  } pda_s1_t;

  // Word after the band and decimal split stage
  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] dist_cm;
    logic [12:0] q10;
    logic [9:0]  q100;
    logic [6:0]  q1000;
    logic [2:0]  band;
  } pda_s2_t;

  function automatic logic [7:0] seg_of(input logic [3:0] digit);
    logic [7:0] seg;
    unique case (digit)
      4'd0:    seg = 8'd192;
      4'd1:    seg = 8'd249;
      4'd2:    seg = 8'd164;
      4'd3:    seg = 8'd176;
      4'd4:    seg = 8'd153;
      4'd5:    seg = 8'd146;
      4'd6:    seg = 8'd130;
      4'd7:    seg = 8'd248;
      4'd8:    seg = 8'd128;
      4'd9:    seg = 8'd152;
      default: seg = 8'd192;
    endcase
    return seg;
  endfunction

  function automatic logic [3:0] relay_of(input logic [2:0] band);
    logic [3:0] rel;
    unique case (band)
      BAND_FAR:  rel = 4'hF;
      BAND_B1:   rel = 4'hE;
      BAND_B2:   rel = 4'hD;
      BAND_B3:   rel = 4'hB;
      BAND_B4:   rel = 4'h7;
      BAND_B5:   rel = 4'h3;
      BAND_NEAR: rel = 4'h0;
      default:   rel = 4'hF;
    endcase
    return rel;
  endfunction

  // Half period of the buzzer blink, in refreshes
  function automatic logic [11:0] half_of(input logic [2:0] band);
    logic [11:0] half;
    unique case (band)
      BAND_B1: half = 12'd900;
      BAND_B2: half = 12'd600;
      BAND_B3: half = 12'd300;
      BAND_B4: half = 12'd225;
      BAND_B5: half = 12'd150;
      default: half = 12'd0;
    endcase
    return half;
  endfunction

  function automatic logic [2:0] select_of(input logic [1:0] idx);
    logic [2:0] sel;
    unique case (idx)
      DIGIT_UNITS: sel = 3'd4;
      DIGIT_TENS:  sel = 3'd2;
      DIGIT_HUNDREDS: sel = 3'd1;
      default:     sel = 3'd4;
    endcase
    return sel;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/pda_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pda_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire pda_pkg::pda_in_t in_word_i,
  input  wire logic             cfg_we_i,
  input  wire logic [15:0]      cfg_wdata_i,
  output logic                  valid_o,
  input  wire logic             stall_i,
  output pda_pkg::pda_s1_t      s1_o
);
  import pda_pkg::*;

  logic        valid_q, valid_d;
  logic [1:0]  mode_q;
  logic [31:0] prod_q, prod_d;
  logic [15:0] last_count_q, last_count_d;
  logic [15:0] scale_q, scale_d;
  logic        accept;
  logic        take_echo;
  logic [15:0] mul_a, mul_b;
  logic [31:0] mul_res;

  // Take a word when this stage is empty or moving on
  assign in_stall_o = valid_q && stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign take_echo  = accept && (in_word_i.mode == MODE_ECHO);

  // Share one multiplier between new echoes and scale writes
  assign mul_a   = take_echo ? in_word_i.echo_count : last_count_q;
  assign mul_b   = cfg_we_i ? cfg_wdata_i : scale_q;
  assign mul_res = {16'd0, mul_a} * {16'd0, mul_b};

  always_comb begin
    valid_d      = valid_q;
    prod_d       = prod_q;
    last_count_d = last_count_q;
    scale_d      = scale_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (!stall_i) begin
      valid_d = 1'b0;
    end
    if (take_echo || cfg_we_i) begin
      prod_d = mul_res;
    end
    if (take_echo) begin
      last_count_d = in_word_i.echo_count;
    end
    if (cfg_we_i) begin
      scale_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= 1'b0;
      prod_q       <= 32'd0;
      last_count_q <= 16'd0;
      scale_q      <= SCALE_RESET;
    end else begin
      valid_q      <= valid_d;
      prod_q       <= prod_d;
      last_count_q <= last_count_d;
      scale_q      <= scale_d;
    end
  end

  // Hold the event code with the word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= in_word_i.mode;
    end
  end

  assign valid_o     = valid_q;
  assign s1_o.mode   = mode_q;
  assign s1_o.prod   = prod_q;

endmodule

`default_nettype wire

// ----- hw/rtl/pda_split.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pda_split (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  stall_o,
  input  wire pda_pkg::pda_s1_t s1_i,
  output logic                  valid_o,
  input  wire logic             stall_i,
  output pda_pkg::pda_s2_t      s2_o
);
  import pda_pkg::*;

  logic          valid_q, valid_d;
  logic          advance;
  logic [15:0]   dist_int;
  logic [32:0]   p10, p100, p1000;
  logic [2:0]    band;
  pda_s2_t       s2_d, s2_q;

  assign stall_o = valid_q && stall_i;
  assign advance = valid_i && !stall_o;

  // Split the integer distance into decimal quotients
  assign dist_int = s1_i.prod[31:16];
  assign p10      = {17'd0, dist_int} * {16'd0, RECIP_10};
  assign p100     = {17'd0, dist_int} * {16'd0, RECIP_100};
  assign p1000    = {17'd0, dist_int} * {16'd0, RECIP_1000};

  // Classify the full-precision distance
  always_comb begin
    priority if (s1_i.prod > LIMIT_200) begin
      band = BAND_FAR;
    end else if (s1_i.prod > LIMIT_180) begin
      band = BAND_B1;
    end else if (s1_i.prod > LIMIT_120) begin
      band = BAND_B2;
    end else if (s1_i.prod > LIMIT_80) begin
      band = BAND_B3;
    end else if (s1_i.prod > LIMIT_50) begin
      band = BAND_B4;
    end else if (s1_i.prod > LIMIT_20) begin
      band = BAND_B5;
    end else begin
      band = BAND_NEAR;
    end
  end

  always_comb begin
    s2_d.mode    = s1_i.mode;
    s2_d.dist_cm = dist_int;
    s2_d.q10     = p10[31:19];
    s2_d.q100    = p100[32:23];
    s2_d.q1000   = p1000[32:26];
    s2_d.band    = band;
  end

  always_comb begin
    valid_d = valid_q;
    if (advance) begin
      valid_d = 1'b1;
    end else if (!stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s2_q <= s2_d;
    end
  end

  assign valid_o = valid_q;
  assign s2_o    = s2_q;

endmodule

`default_nettype wire

// ----- hw/rtl/pda_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pda_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  stall_o,
  input  wire pda_pkg::pda_s2_t s2_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output pda_pkg::pda_out_t     out_word_o
);
  import pda_pkg::*;

  logic        out_valid_q, out_valid_d;
  logic        advance;
  logic        alt_q, alt_d;
  logic [2:0]  band_q, band_d;
  logic        phase_q, phase_d;
  logic [11:0] count_q, count_d;
  logic [11:0] count_inc;
  logic [1:0]  idx_q, idx_d;
  logic        middle;
  logic        relatch;
  logic        refresh_done;
  logic [3:0]  units, tens, hundreds, digit;
  logic [15:0] units_w;
  logic [12:0] tens_w;
  logic [9:0]  hundreds_w;
  pda_out_t    word_d, word_q;

  assign stall_o = out_valid_q && out_stall_i;
  assign advance = valid_i && !stall_o;

  assign middle       = (band_q != BAND_FAR) && (band_q != BAND_NEAR);
  assign refresh_done = (idx_q >= DIGIT_HUNDREDS);
  assign count_inc    = count_q + 12'd1;

  // Advance scan, blink timing, alternate mode and band latch for one word
  always_comb begin
    alt_d   = alt_q;
    band_d  = band_q;
    phase_d = phase_q;
    count_d = count_q;
    idx_d   = idx_q;
    relatch = 1'b0;
    unique case (s2_i.mode)
      MODE_BUTTON: alt_d = !alt_q;
      MODE_TICK: begin
        idx_d = refresh_done ? DIGIT_UNITS : idx_q + 2'd1;
        if (refresh_done && middle) begin
          if (count_inc >= half_of(band_q)) begin
            count_d = 12'd0;
            if (!phase_q) begin
              phase_d = 1'b1;
            end else begin
              relatch = 1'b1;
            end
          end else begin
            count_d = count_inc;
          end
        end
      end
      default: ;
    endcase
    if (relatch || !middle) begin
      band_d  = s2_i.band;
      phase_d = 1'b0;
      count_d = 12'd0;
    end
  end

  // Recover the digits from the quotients
  assign units_w    = s2_i.dist_cm - {s2_i.q10, 3'b000} - {2'b00, s2_i.q10, 1'b0};
  assign tens_w     = s2_i.q10 - {s2_i.q100, 3'b000} - {2'b00, s2_i.q100, 1'b0};
  assign hundreds_w = s2_i.q100 - {s2_i.q1000, 3'b000} - {2'b00, s2_i.q1000, 1'b0};
  assign units      = units_w[3:0];
  assign tens       = tens_w[3:0];
  assign hundreds   = hundreds_w[3:0];

  always_comb begin
    unique case (idx_q)
      DIGIT_UNITS: digit = units;
      DIGIT_TENS:  digit = tens;
      default:     digit = hundreds;
    endcase
  end

  // Build the result word from the updated state
  always_comb begin
    word_d.relays = relay_of(band_d);
    if (band_d == BAND_FAR) begin
      word_d.buzzer_on = 1'b0;
    end else if (band_d == BAND_NEAR) begin
      word_d.buzzer_on = 1'b1;
    end else begin
      word_d.buzzer_on = phase_d;
    end
    word_d.indicator_led = alt_d && ((band_d == BAND_NEAR) ||
                                     ((band_d == BAND_B5) && phase_d));
    word_d.digit_select  = select_of(idx_q);
    word_d.segments      = seg_of(digit);
    word_d.distance_cm   = s2_i.dist_cm;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      alt_q       <= 1'b0;
      band_q      <= BAND_FAR;
      phase_q     <= 1'b0;
      count_q     <= 12'd0;
      idx_q       <= DIGIT_UNITS;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance) begin
        alt_q   <= alt_d;
        band_q  <= band_d;
        phase_q <= phase_d;
        count_q <= count_d;
        idx_q   <= idx_d;
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i) begin
    if (advance) begin
      word_q <= word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = word_q;

endmodule

`default_nettype wire

// ----- hw/rtl/parking_distance_alarm_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Parking distance alarm: one result word for every input word (digit tick, echo
// measurement or button press), in order. The block takes a word in every cycle while not
// stalled. The result passes through three register stages:
// the multiply of echo count by the scale register, the band compare with the decimal
// split of the distance, and the blink/scan control with the result register. Stall on
// the result side backs up through the stages; up to three words are held in flight.
// Scale writes take effect on the stored echo count and must be made while idle.
module parking_distance_alarm_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire pda_pkg::pda_in_t  in_word_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output pda_pkg::pda_out_t      out_word_o,
  input  wire logic              cfg_we_i,
  input  wire logic [15:0]       cfg_wdata_i
);
  import pda_pkg::*;

  logic    s1_valid, s1_stall;
  logic    s2_valid, s2_stall;
  pda_s1_t s1_word;
  pda_s2_t s2_word;

  pda_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .valid_o     (s1_valid),
    .stall_i     (s1_stall),
    .s1_o        (s1_word)
  );

  pda_split u_split (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .stall_o (s1_stall),
    .s1_i    (s1_word),
    .valid_o (s2_valid),
    .stall_i (s2_stall),
    .s2_o    (s2_word)
  );

  pda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s2_valid),
    .stall_o     (s2_stall),
    .s2_i        (s2_word),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/pda_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pda_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire pda_pkg::pda_in_t  in_word_i,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire pda_pkg::pda_out_t out_word_o,
  input wire logic              cfg_we_i,
  input wire logic [15:0]       cfg_wdata_i
);

  // Stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed under stall");

  // Exactly one digit driven
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot(out_word_o.digit_select))
    else $error("digit select not one-hot");

  // Relay pattern belongs to a band
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.relays == 4'hF || out_word_o.relays == 4'hE ||
                     out_word_o.relays == 4'hD || out_word_o.relays == 4'hB ||
                     out_word_o.relays == 4'h7 || out_word_o.relays == 4'h3 ||
                     out_word_o.relays == 4'h0))
    else $error("relay pattern outside band set");

  // Buzzer silent when far, steady when near
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.relays != 4'hF || !out_word_o.buzzer_on) &&
                    (out_word_o.relays != 4'h0 || out_word_o.buzzer_on))
    else $error("buzzer level disagrees with band");

  // Indicator only in the two nearest bands
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.indicator_led |->
      (out_word_o.relays == 4'h0 || out_word_o.relays == 4'h3))
    else $error("indicator lit outside near bands");

endmodule

bind parking_distance_alarm_core pda_checker u_pda_checker (.*);

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import pda_pkg::*;

  // Mode code that the block ignores apart from producing a word
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 4;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  pda_in_t in_word_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  pda_out_t out_word_o;
  logic cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  parking_distance_alarm_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Predicted alarm state
  logic [15:0] scale_reg = SCALE_RESET;
  logic [15:0] echo_held = '0;
  logic alt_on = 1'b0;
  logic [2:0] band_held = BAND_FAR;
  logic buzz_half = 1'b0;
  logic [11:0] refresh_count = '0;
  logic [1:0] scan_pos = DIGIT_UNITS;

  pda_in_t events_to_send[$];
  pda_out_t alarm_words_due[$];

  int mismatch_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_hold = 0;
  int stall_rate = 0;
  logic in_fire = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Apply one event to the predicted state and build the word it should produce
  function automatic pda_out_t predict_alarm_word(input pda_in_t w);
    pda_out_t r;
    logic [1:0] shown;
    logic cycle_end;
    logic [11:0] half_len;
    logic [31:0] prod;
    logic [15:0] dist_val;
    logic [15:0] digit;
    shown = scan_pos;
    cycle_end = 1'b0;
    case (band_held)
      BAND_B1: half_len = 12'd900;
      BAND_B2: half_len = 12'd600;
      BAND_B3: half_len = 12'd300;
      BAND_B4: half_len = 12'd225;
      BAND_B5: half_len = 12'd150;
      default: half_len = 12'd0;
    endcase
    case (w.mode)
      MODE_ECHO:   echo_held = w.echo_count;
      MODE_BUTTON: alt_on = ~alt_on;
      MODE_TICK: begin
        scan_pos = (shown >= DIGIT_HUNDREDS) ? DIGIT_UNITS : shown + 2'd1;
        // count a refresh toward the blink half while a middle band is latched
        if (shown >= DIGIT_HUNDREDS && band_held != BAND_FAR && band_held != BAND_NEAR) begin
          refresh_count = refresh_count + 12'd1;
          if (refresh_count >= half_len) begin
            refresh_count = '0;
            if (!buzz_half) buzz_half = 1'b1;
            else cycle_end = 1'b1;
          end
        end
      end
      default: ;
    endcase

    prod = {16'd0, echo_held} * {16'd0, scale_reg};
    dist_val = prod[31:16];

    // latch the band again at a cycle end or while outside the blinking bands
    if (cycle_end || band_held == BAND_FAR || band_held == BAND_NEAR) begin
      if (prod > LIMIT_200) band_held = BAND_FAR;
      else if (prod > LIMIT_180) band_held = BAND_B1;
      else if (prod > LIMIT_120) band_held = BAND_B2;
      else if (prod > LIMIT_80) band_held = BAND_B3;
      else if (prod > LIMIT_50) band_held = BAND_B4;
      else if (prod > LIMIT_20) band_held = BAND_B5;
      else band_held = BAND_NEAR;
      buzz_half = 1'b0;
      refresh_count = '0;
    end

    case (shown)
      DIGIT_UNITS: begin
        digit = dist_val % 16'd10;
        r.digit_select = 3'd4;
      end
      DIGIT_TENS: begin
        digit = (dist_val / 16'd10) % 16'd10;
        r.digit_select = 3'd2;
      end
      default: begin
        digit = (dist_val / 16'd100) % 16'd10;
        r.digit_select = 3'd1;
      end
    endcase
    case (digit)
      16'd0:   r.segments = 8'd192;
      16'd1:   r.segments = 8'd249;
      16'd2:   r.segments = 8'd164;
      16'd3:   r.segments = 8'd176;
      16'd4:   r.segments = 8'd153;
      16'd5:   r.segments = 8'd146;
      16'd6:   r.segments = 8'd130;
      16'd7:   r.segments = 8'd248;
      16'd8:   r.segments = 8'd128;
      default: r.segments = 8'd152;
    endcase
    case (band_held)
      BAND_B1:   r.relays = 4'hE;
      BAND_B2:   r.relays = 4'hD;
      BAND_B3:   r.relays = 4'hB;
      BAND_B4:   r.relays = 4'h7;
      BAND_B5:   r.relays = 4'h3;
      BAND_NEAR: r.relays = 4'h0;
      default:   r.relays = 4'hF;
    endcase
    if (band_held == BAND_FAR) r.buzzer_on = 1'b0;
    else if (band_held == BAND_NEAR) r.buzzer_on = 1'b1;
    else r.buzzer_on = buzz_half;
    r.indicator_led = alt_on &&
        (band_held == BAND_NEAR || (band_held == BAND_B5 && buzz_half));
    r.distance_cm = dist_val;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h", cycle_count, what, got, want);
  endtask

  task automatic check_field(input string what, input int unsigned got,
                             input int unsigned want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // Echo count: raw random, or aimed at a band edge or a random distance under the current scale
  function automatic logic [15:0] pick_echo();
    logic [31:0] raw;
    longint unsigned cnt;
    longint unsigned target;
    raw = $urandom;
    if (scale_reg == 16'd0 || $urandom_range(3) == 0) return raw[15:0];
    if ($urandom_range(1) == 0) begin
      case ($urandom_range(5))
        0: target = 20;
        1: target = 50;
        2: target = 80;
        3: target = 120;
        4: target = 180;
        default: target = 200;
      endcase
    end else begin
      target = $urandom_range(260);
    end
    cnt = (target << 16) / scale_reg + $urandom_range(2);
    if (cnt > 0) cnt = cnt - 1;
    if (cnt > 65535) cnt = 65535;
    return cnt[15:0];
  endfunction

  function automatic pda_in_t make_event(input logic [1:0] mode, input logic [15:0] count);
    pda_in_t w;
    w.mode = mode;
    w.echo_count = count;
    return w;
  endfunction

  task automatic queue_random_events(input int n);
    pda_in_t w;
    int unsigned pick;
    logic [31:0] raw;
    repeat (n) begin
      pick = $urandom_range(99);
      raw = $urandom;
      w.echo_count = raw[15:0];
      if (pick < 88) w.mode = MODE_TICK;
      else if (pick < 94) begin
        w.mode = MODE_ECHO;
        w.echo_count = pick_echo();
      end else if (pick < 99) w.mode = MODE_BUTTON;
      else w.mode = MODE_UNUSED;
      events_to_send.push_back(w);
    end
  endtask

  // Hold off until every queued event is taken and every word has come back
  task automatic drain();
    while (events_to_send.size() != 0 || in_valid_i || alarm_words_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_scale(input logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    scale_reg = value;
    @(posedge clk_i);
  endtask

  // Sender: bursts of words with random gaps, payload held while stalled
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_fire)) begin
      if (gap_left > 0 || events_to_send.size() == 0) begin
        in_valid_i <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        in_word_i <= events_to_send.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left == 0) burst_left = $urandom_range(1, 48);
        burst_left--;
        if (burst_left == 0) gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 10);
      end
    end
  end

  // Receiver: stall rate changes over windows of random length
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_hold == 0) begin
        case ($urandom_range(3))
          0: stall_rate = 0;
          1: stall_rate = 1;
          2: stall_rate = 4;
          default: stall_rate = 7;
        endcase
        stall_hold = $urandom_range(20, 200);
      end
      stall_hold--;
      out_stall_i <= ($urandom_range(7) < stall_rate);
    end
  end

  // Predict on each accepted event, compare each accepted result word
  always @(posedge clk_i) begin
    pda_out_t want;
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) alarm_words_due.push_back(predict_alarm_word(in_word_i));
      if (out_valid_o && !out_stall_i) begin
        if (alarm_words_due.size() == 0) begin
          report_mismatch("word with nothing due", 32'(out_word_o.distance_cm), 0);
        end else begin
          want = alarm_words_due.pop_front();
          check_field("relays", 32'(out_word_o.relays), 32'(want.relays));
          check_field("buzzer_on", 32'(out_word_o.buzzer_on), 32'(want.buzzer_on));
          check_field("indicator_led", 32'(out_word_o.indicator_led),
                      32'(want.indicator_led));
          check_field("digit_select", 32'(out_word_o.digit_select), 32'(want.digit_select));
          check_field("segments", 32'(out_word_o.segments), 32'(want.segments));
          check_field("distance_cm", 32'(out_word_o.distance_cm), 32'(want.distance_cm));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset scale: zero distance, huge distance, unused mode, button toggles
    events_to_send.push_back(make_event(MODE_TICK, 16'h0000));
    events_to_send.push_back(make_event(MODE_TICK, 16'hFFFF));
    events_to_send.push_back(make_event(MODE_TICK, 16'h0000));
    events_to_send.push_back(make_event(MODE_ECHO, 16'hFFFF));
    events_to_send.push_back(make_event(MODE_TICK, 16'h0000));
    events_to_send.push_back(make_event(MODE_TICK, 16'h5555));
    events_to_send.push_back(make_event(MODE_TICK, 16'hAAAA));
    events_to_send.push_back(make_event(MODE_BUTTON, 16'h0000));
    events_to_send.push_back(make_event(MODE_UNUSED, 16'hFFFF));
    events_to_send.push_back(make_event(MODE_ECHO, 16'h0000));
    events_to_send.push_back(make_event(MODE_TICK, 16'h0000));
    events_to_send.push_back(make_event(MODE_BUTTON, 16'h0000));
    drain();

    // Quarter scale: exactly 20 cm, then the LED in alternate mode, then a blinking band
    write_scale(16'd16384);
    events_to_send.push_back(make_event(MODE_ECHO, 16'd80));
    events_to_send.push_back(make_event(MODE_TICK, 16'd0));
    events_to_send.push_back(make_event(MODE_BUTTON, 16'd0));
    events_to_send.push_back(make_event(MODE_TICK, 16'd0));
    events_to_send.push_back(make_event(MODE_ECHO, 16'd801));
    events_to_send.push_back(make_event(MODE_TICK, 16'd0));
    events_to_send.push_back(make_event(MODE_ECHO, 16'd81));
    events_to_send.push_back(make_event(MODE_TICK, 16'd0));
    events_to_send.push_back(make_event(MODE_BUTTON, 16'd0));
    events_to_send.push_back(make_event(MODE_ECHO, 16'd800));
    events_to_send.push_back(make_event(MODE_TICK, 16'd0));
    drain();

    // Random phases across several scales, extremes among them
    write_scale(SCALE_RESET);
    queue_random_events(420);
    drain();
    write_scale(16'hFFFF);
    queue_random_events(380);
    drain();
    write_scale(16'd0);
    queue_random_events(100);
    drain();
    write_scale(16'd32768);
    queue_random_events(500);
    drain();
    write_scale(16'($urandom_range(1, 65534)));
    queue_random_events(400);
    drain();

    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
